[src/ksr_pkg.sv]
// Shared types, scan codes and cursor tables for the keyboard scancode remapper.
// No dependencies; ksr_decode, ksr_emit and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package ksr_pkg;

   localparam logic [7:0] K_ESC     = 8'h01;
   localparam logic [7:0] K_1       = 8'h02;
   localparam logic [7:0] K_2       = 8'h03;
   localparam logic [7:0] K_LCTRL   = 8'h1D;
   localparam logic [7:0] K_A       = 8'h1E;
   localparam logic [7:0] K_X       = 8'h2D;
   localparam logic [7:0] K_N       = 8'h31;
   localparam logic [7:0] K_PRTSC   = 8'h37;
   localparam logic [7:0] K_LALT    = 8'h38;
   localparam logic [7:0] K_CAPS    = 8'h3A;
   localparam logic [7:0] K_F1      = 8'h3B;
   localparam logic [7:0] K_NUMLOCK = 8'h45;

   localparam int TBL_DEPTH = 8;

   localparam logic [7:0] MAIN_IN  [TBL_DEPTH] = '{8'h26, 8'h28, 8'h19, 8'h27,
                                                   8'h1A, 8'h1B, 8'h18, 8'h25};
   localparam logic [7:0] MAIN_OUT [TBL_DEPTH] = '{8'h4B, 8'h4D, 8'h48, 8'h50,
                                                   8'h49, 8'h51, 8'h47, 8'h4F};
   localparam logic [7:0] ALT_IN   [TBL_DEPTH] = '{8'h25, 8'h27, 8'h18, 8'h26,
                                                   8'h19, 8'h1A, 8'h17, 8'h24};
   localparam logic [7:0] ALT_OUT  [TBL_DEPTH] = '{8'h4B, 8'h4D, 8'h48, 8'h50,
                                                   8'h49, 8'h51, 8'h47, 8'h4F};

   typedef struct packed {
      logic [7:0] code;
      logic       up;
      logic       e0;
      logic       e1;
   } stroke_type;

   // Strokes caused by one input; cnt is 0..3
   typedef struct packed {
      stroke_type [2:0] slot;
      logic [1:0]       cnt;
   } run_type;

   typedef struct packed {
      logic escape_held;
      logic right_alt_held;
      logic remap_mode;
      logic cursor_toggle_style;
      logic cursor_active;
      logic alternate_table;
      logic halted;
   } state_type;

   localparam state_type STATE_RESET = '{escape_held: 1'b0, right_alt_held: 1'b0,
                                         remap_mode: 1'b1, cursor_toggle_style: 1'b0,
                                         cursor_active: 1'b0, alternate_table: 1'b0,
                                         halted: 1'b0};

   // Cursor-mode lookup: bit 8 is hit, bits 7:0 the navigation code
   function automatic logic [8:0] cursor_lookup(input logic [7:0] code, input logic alt);
      logic [8:0] res;
      res = '0;
      for (int i = 0; i < TBL_DEPTH; i++) begin
         if (alt ? (ALT_IN[i] == code) : (MAIN_IN[i] == code)) begin
            res = {1'b1, alt ? ALT_OUT[i] : MAIN_OUT[i]};
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[src/ksr_req_if.sv]
// Input stroke channel: valid/ready plus one set-1 stroke.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ksr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_code;
   logic       key_up;
   logic       ext_e0;
   logic       ext_e1;

   modport source (output valid, key_code, key_up, ext_e0, ext_e1, input ready);
   modport sink   (input valid, key_code, key_up, ext_e0, ext_e1, output ready);
endinterface

`default_nettype wire

[src/ksr_rsp_if.sv]
// Result stroke channel: valid/ready plus one emitted stroke.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ksr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_scan;
   logic       out_up;
   logic       out_e0;
   logic       out_e1;
   logic       last_of_run;

   modport source (output valid, out_scan, out_up, out_e0, out_e1, last_of_run,
                   input ready);
   modport sink   (input valid, out_scan, out_up, out_e0, out_e1, last_of_run,
                   output ready);
endinterface

`default_nettype wire

[src/ksr_decode.sv]
// Combinational rewrite of one stroke: next mode state and up to three strokes.
// Depends on ksr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksr_decode import ksr_pkg::*; (
   input  stroke_type stroke,
   input  state_type  st_cur,
   output state_type  st_next,
   output run_type    run
);

   logic       down;
   logic       cont;
   logic [8:0] hit;

   assign down = ~stroke.up;

   always_comb begin
      st_next = st_cur;
      run     = '0;
      cont    = 1'b1;
      hit     = '0;

      if (st_cur.halted) begin
         cont = 1'b0;
      end else if (stroke.code == K_ESC) begin
         st_next.escape_held = down;
      end else if (stroke.code == K_LALT && stroke.e0) begin
         // right Alt: cursor mode control, never emitted
         if (st_cur.cursor_toggle_style) begin
            if (down && !st_cur.right_alt_held) begin
               st_next.cursor_active = ~st_cur.cursor_active;
            end
         end else begin
            st_next.cursor_active = down;
         end
         st_next.right_alt_held = down;
         cont = 1'b0;
      end else if (stroke.code == K_LALT) begin
         run.slot[0] = '{code: K_LCTRL, up: stroke.up, e0: 1'b0, e1: 1'b0};
         run.cnt     = 2'd1;
         cont        = 1'b0;
      end else if (stroke.code == K_LCTRL) begin
         run.slot[0] = '{code: K_LALT, up: stroke.up, e0: 1'b0, e1: 1'b0};
         run.cnt     = 2'd1;
         cont        = 1'b0;
      end

      // Esc chords, press only
      if (cont && st_next.escape_held && down) begin
         case (stroke.code)
            K_X: begin
               st_next.halted = 1'b1;
               cont = 1'b0;
            end
            K_1: begin
               st_next.remap_mode = 1'b0;
               cont = 1'b0;
            end
            K_2: begin
               st_next.remap_mode = 1'b1;
               cont = 1'b0;
            end
            K_F1: begin
               st_next.cursor_toggle_style = ~st_cur.cursor_toggle_style;
               cont = 1'b0;
            end
            K_N: begin
               run.slot[0] = '{code: K_NUMLOCK, up: 1'b0, e0: 1'b0, e1: 1'b0};
               run.slot[1] = '{code: K_NUMLOCK, up: 1'b1, e0: 1'b0, e1: 1'b0};
               run.cnt     = 2'd2;
            end
            K_A: begin
               st_next.alternate_table = ~st_cur.alternate_table;
            end
            default: begin
            end
         endcase
      end

      if (cont && st_next.remap_mode) begin
         hit = cursor_lookup(stroke.code, st_next.alternate_table);
         if (stroke.code == K_CAPS) begin
            run.slot[run.cnt] = '{code: K_LALT, up: stroke.up, e0: 1'b0, e1: 1'b0};
            run.cnt           = run.cnt + 2'd1;
            cont              = 1'b0;
         end else if (st_next.alternate_table && stroke.code == K_PRTSC && stroke.e0) begin
            cont = 1'b0;
         end else if (st_next.cursor_active && hit[8]) begin
            run.slot[run.cnt] = '{code: hit[7:0], up: stroke.up, e0: 1'b0, e1: 1'b0};
            run.cnt           = run.cnt + 2'd1;
            cont              = 1'b0;
         end
      end

      if (cont) begin
         run.slot[run.cnt] = stroke;
         run.cnt           = run.cnt + 2'd1;
      end
   end

endmodule

`default_nettype wire

[src/ksr_emit.sv]
// Result buffer: holds one run of up to three strokes and sends one per beat.
// Depends on ksr_pkg and ksr_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module ksr_emit import ksr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  run_type    run,
   output logic       buf_free,
   output logic [1:0] idx,
   output logic [1:0] cnt,
   ksr_rsp_if.source  rsp
);

   run_type    run_ff, run_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       last;
   logic       take;
   stroke_type cur;

   assign last     = (idx_ff == run_ff.cnt - 2'd1);
   assign take     = valid_ff && rsp.ready;
   assign buf_free = !valid_ff || (take && last);

   always_comb begin
      run_in   = run_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (buf_free) begin
         // a run with no strokes leaves the buffer empty
         valid_in = load && (run.cnt != 2'd0);
         run_in   = run;
         idx_in   = 2'd0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      run_ff <= run_in;
   end

   assign cur             = run_ff.slot[idx_ff];
   assign rsp.valid       = valid_ff;
   assign rsp.out_scan    = cur.code;
   assign rsp.out_up      = cur.up;
   assign rsp.out_e0      = cur.e0;
   assign rsp.out_e1      = cur.e1;
   assign rsp.last_of_run = last;
   assign idx             = idx_ff;
   assign cnt             = run_ff.cnt;

endmodule

`default_nettype wire

[src/keyboard_scancode_remapper.sv]
// Top level of the keyboard scancode remapper: input register, mode state, decode, result buffer.
// Depends on ksr_pkg, ksr_req_if, ksr_rsp_if, ksr_decode, ksr_emit.
//
//   channel   dir   payload                                        handshake
//   req_bus   in    key_code[7:0] key_up ext_e0 ext_e1             valid/ready
//   rsp_bus   out   out_scan[7:0] out_up out_e0 out_e1 last_of_run valid/ready
//
// An input stroke is registered in the input register, then, once the result buffer
// is free, decoded and loaded into the result buffer, which registers its run and
// offers the first result on rsp_bus.
// The buffer sends one stroke per beat; each input causes n (0..3) strokes.
// Reset is synchronous: it clears the mode state (remap mode on) and empties both stages.
// A stall on rsp_bus holds the buffer; one more input is taken into the input register.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_scancode_remapper import ksr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   ksr_req_if.sink   req_bus,
   ksr_rsp_if.source rsp_bus
);

   stroke_type in_ff, in_in;
   logic       in_valid_ff, in_valid_in;
   state_type  state_ff, state_in;
   state_type  st_next;
   run_type    run;
   logic       buf_free;
   logic       load;
   logic       accept;
   logic [1:0] emit_idx;
   logic [1:0] emit_cnt;

   assign load           = in_valid_ff && buf_free;
   assign req_bus.ready  = !in_valid_ff || buf_free;
   assign accept         = req_bus.valid && req_bus.ready;

   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_in       = '{code: req_bus.key_code, up: req_bus.key_up,
                         e0: req_bus.ext_e0, e1: req_bus.ext_e1};
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
      state_in = load ? st_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
      in_ff <= in_in;
   end

   ksr_decode u_decode (
      .stroke  (in_ff),
      .st_cur  (state_ff),
      .st_next (st_next),
      .run     (run)
   );

   ksr_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .run      (run),
      .buf_free (buf_free),
      .idx      (emit_idx),
      .cnt      (emit_cnt),
      .rsp      (rsp_bus)
   );

`ifndef ASSERT_OFF
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff.halted |=> state_ff.halted)
      else $error("halted state cleared without reset");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (load && state_ff.halted) |=> !rsp_bus.valid)
      else $error("stroke emitted while halted");

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (emit_cnt != 2'd0 && emit_idx < emit_cnt))
      else $error("result index outside buffered run");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> $stable(emit_idx))
      else $error("result buffer advanced on stalled beat");
`endif

endmodule

`default_nettype wire
